// ----- rtl/core/mhd_pkg.sv -----
package mhd_pkg;

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int TYPE_W   = 10;
    localparam int LABEL_W  = 33;
    localparam int LEN_W    = 26;
    localparam int ACC_W    = 27;
    localparam int TDATA_W  = 80;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HDR_END = 2'd2;

    // escape patterns of each header part
    localparam logic [2:0]  T0_ESC   = 3'b111;
    localparam logic [1:0]  L0_ESC   = 2'b11;
    localparam logic [7:0]  PART8_ESC = 8'hFF;
    localparam logic [10:0] N0_ESC   = 11'h7FF;
    localparam logic [23:0] N24_ESC  = 24'hFFFFFF;

    // index of the final byte in a run of whole middle bytes
    localparam logic [1:0]  MID_LAST = 2'd2;

    // Header byte positions. Part boundaries fall at fixed bit offsets
    // within a byte, so each state knows where the fields of the byte lie.
    typedef enum logic [2:0] {
        ST_T0,      // type part 0 in [7:5]
        ST_T_LO,    // low 3 bits of an 8-bit type part in [7:5]
        ST_L1_LO,   // low 5 bits of label part 1 in [7:3]
        ST_L2_MID,  // whole bytes of label part 2
        ST_L2_LO,   // low 5 bits of label part 2 in [7:3]
        ST_N0_LO,   // low 8 bits of length part 0
        ST_N_MID,   // whole bytes of a 24-bit length part
        ST_PAY      // payload words
    } hdr_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TYPE_W-1:0]  ptype;
        logic [LABEL_W-1:0] label;
        logic [LEN_W-1:0]   length;
        logic [BYTE_W-1:0]  pbyte;
        logic               last;
        logic               trunc;
    } result_t;

endpackage

// ----- rtl/core/mhd_front.sv -----
module mhd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mhd_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        in_end,
    output logic                        res_valid,
    input  logic                        res_ready,
    output mhd_pkg::result_t            res
);

    mhd_pkg::hdr_state_t state_reg, state_next;
    logic                esc3_reg, esc3_next;
    logic [1:0]          cnt_reg, cnt_next;

    logic [mhd_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [mhd_pkg::TYPE_W-1:0]  type_reg, type_next;
    logic [mhd_pkg::LABEL_W-1:0] label_reg, label_next;
    logic [mhd_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [mhd_pkg::LEN_W-1:0]   remain_reg, remain_next;

    logic        accept;
    logic [2:0]  t0;
    logic [1:0]  l0;
    logic [7:0]  t_part;
    logic [7:0]  l1_part;
    logic [31:0] l2_part;
    logic [10:0] n0_part;
    logic [23:0] n_part;
    logic [mhd_pkg::TYPE_W-1:0]  type_sum;
    logic [mhd_pkg::LABEL_W-1:0] label_l1;
    logic [mhd_pkg::LABEL_W-1:0] label_l2;
    logic [mhd_pkg::LEN_W-1:0]   len_sum;
    logic [mhd_pkg::LEN_W-1:0]   len_final;
    logic [mhd_pkg::LEN_W-1:0]   remain_dec;
    logic t0_esc, l0_esc, tpart_esc, l1_esc, n0_esc, npart_esc;
    logic hdr_done, hdr_last;

    assign in_ready = res_ready;
    assign accept   = in_valid && res_ready;

    assign t0      = in_byte[7:5];
    assign l0      = in_byte[4:3];
    assign t_part  = {acc_reg[4:0], in_byte[7:5]};
    assign l1_part = {acc_reg[2:0], in_byte[7:3]};
    assign l2_part = {acc_reg[26:0], in_byte[7:3]};
    assign n0_part = {acc_reg[2:0], in_byte};
    assign n_part  = {acc_reg[15:0], in_byte};

    assign type_sum   = type_reg + mhd_pkg::TYPE_W'(t_part);
    assign label_l1   = label_reg + mhd_pkg::LABEL_W'(l1_part);
    assign label_l2   = label_reg + mhd_pkg::LABEL_W'(l2_part);
    assign len_sum    = len_reg + mhd_pkg::LEN_W'(n_part);
    assign remain_dec = remain_reg - mhd_pkg::LEN_W'(1);

    assign t0_esc    = (t0 == mhd_pkg::T0_ESC);
    assign l0_esc    = (l0 == mhd_pkg::L0_ESC);
    assign tpart_esc = !esc3_reg && (t_part == mhd_pkg::PART8_ESC);
    assign l1_esc    = (l1_part == mhd_pkg::PART8_ESC);
    assign n0_esc    = (n0_part == mhd_pkg::N0_ESC);
    assign npart_esc = !esc3_reg && (n_part == mhd_pkg::N24_ESC);

    assign hdr_done = ((state_reg == mhd_pkg::ST_N0_LO) && !n0_esc) ||
                      ((state_reg == mhd_pkg::ST_N_MID) && (cnt_reg == mhd_pkg::MID_LAST) &&
                       !npart_esc);
    assign len_final = (state_reg == mhd_pkg::ST_N0_LO) ? mhd_pkg::LEN_W'(n0_part) : len_sum;
    assign hdr_last  = (len_final == '0) || in_end;

    // next state
    always_comb begin
        state_next = state_reg;
        esc3_next  = esc3_reg;
        cnt_next   = cnt_reg;
        if (accept) begin
            unique case (state_reg)
                mhd_pkg::ST_T0: begin
                    if (t0_esc) begin
                        state_next = mhd_pkg::ST_T_LO;
                        esc3_next  = 1'b0;
                    end else begin
                        state_next = l0_esc ? mhd_pkg::ST_L1_LO : mhd_pkg::ST_N0_LO;
                    end
                end
                mhd_pkg::ST_T_LO: begin
                    if (tpart_esc) begin
                        esc3_next = 1'b1;
                    end else begin
                        state_next = l0_esc ? mhd_pkg::ST_L1_LO : mhd_pkg::ST_N0_LO;
                    end
                end
                mhd_pkg::ST_L1_LO: begin
                    if (l1_esc) begin
                        state_next = mhd_pkg::ST_L2_MID;
                        cnt_next   = 2'd0;
                    end else begin
                        state_next = mhd_pkg::ST_N0_LO;
                    end
                end
                mhd_pkg::ST_L2_MID: begin
                    if (cnt_reg == mhd_pkg::MID_LAST) begin
                        state_next = mhd_pkg::ST_L2_LO;
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
                mhd_pkg::ST_L2_LO: begin
                    state_next = mhd_pkg::ST_N0_LO;
                end
                mhd_pkg::ST_N0_LO: begin
                    if (n0_esc) begin
                        state_next = mhd_pkg::ST_N_MID;
                        esc3_next  = 1'b0;
                        cnt_next   = 2'd0;
                    end else begin
                        state_next = hdr_last ? mhd_pkg::ST_T0 : mhd_pkg::ST_PAY;
                    end
                end
                mhd_pkg::ST_N_MID: begin
                    if (cnt_reg != mhd_pkg::MID_LAST) begin
                        cnt_next = cnt_reg + 2'd1;
                    end else if (npart_esc) begin
                        esc3_next = 1'b1;
                        cnt_next  = 2'd0;
                    end else begin
                        state_next = hdr_last ? mhd_pkg::ST_T0 : mhd_pkg::ST_PAY;
                    end
                end
                mhd_pkg::ST_PAY: begin
                    if (remain_dec == '0) begin
                        state_next = mhd_pkg::ST_T0;
                    end
                end
                default: begin
                    state_next = mhd_pkg::ST_T0;
                end
            endcase
            // stream end always restarts parsing
            if (in_end) begin
                state_next = mhd_pkg::ST_T0;
            end
        end
    end

    // datapath and result
    always_comb begin
        acc_next    = acc_reg;
        type_next   = type_reg;
        label_next  = label_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        unique case (state_reg)
            mhd_pkg::ST_T0: begin
                type_next = mhd_pkg::TYPE_W'(t0);
                if (t0_esc) begin
                    acc_next = mhd_pkg::ACC_W'(in_byte[4:0]);
                end else begin
                    label_next = mhd_pkg::LABEL_W'(l0);
                    acc_next   = mhd_pkg::ACC_W'(in_byte[2:0]);
                end
            end
            mhd_pkg::ST_T_LO: begin
                type_next = type_sum;
                if (tpart_esc) begin
                    acc_next = mhd_pkg::ACC_W'(in_byte[4:0]);
                end else begin
                    label_next = mhd_pkg::LABEL_W'(l0);
                    acc_next   = mhd_pkg::ACC_W'(in_byte[2:0]);
                end
            end
            mhd_pkg::ST_L1_LO: begin
                label_next = label_l1;
                acc_next   = mhd_pkg::ACC_W'(in_byte[2:0]);
            end
            mhd_pkg::ST_L2_MID: begin
                acc_next = {acc_reg[mhd_pkg::ACC_W-mhd_pkg::BYTE_W-1:0], in_byte};
            end
            mhd_pkg::ST_L2_LO: begin
                label_next = label_l2;
                acc_next   = mhd_pkg::ACC_W'(in_byte[2:0]);
            end
            mhd_pkg::ST_N0_LO: begin
                len_next = mhd_pkg::LEN_W'(n0_part);
            end
            mhd_pkg::ST_N_MID: begin
                acc_next = {acc_reg[mhd_pkg::ACC_W-mhd_pkg::BYTE_W-1:0], in_byte};
                if (cnt_reg == mhd_pkg::MID_LAST) begin
                    len_next = len_sum;
                end
            end
            mhd_pkg::ST_PAY: begin
                remain_next = remain_dec;
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
        if (hdr_done) begin
            remain_next = len_final;
        end

        res_valid = accept && (hdr_done || (state_reg == mhd_pkg::ST_PAY) || in_end);
        priority if (state_reg == mhd_pkg::ST_PAY) begin
            res.kind   = mhd_pkg::KIND_PAYLOAD;
            res.ptype  = type_reg;
            res.label  = label_reg;
            res.length = len_reg;
            res.pbyte  = in_byte;
            res.last   = (remain_dec == '0) || in_end;
            res.trunc  = in_end && (remain_dec != '0);
        end else if (hdr_done) begin
            res.kind   = mhd_pkg::KIND_HEADER;
            res.ptype  = type_reg;
            res.label  = label_reg;
            res.length = len_final;
            res.pbyte  = '0;
            res.last   = hdr_last;
            res.trunc  = in_end && (len_final != '0);
        end else begin
            res.kind   = mhd_pkg::KIND_HDR_END;
            res.ptype  = '0;
            res.label  = '0;
            res.length = '0;
            res.pbyte  = '0;
            res.last   = 1'b1;
            res.trunc  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mhd_pkg::ST_T0;
            esc3_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            esc3_reg  <= esc3_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg    <= acc_next;
            type_reg   <= type_next;
            label_reg  <= label_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ----- rtl/core/mhd_queue.sv -----
module mhd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  mhd_pkg::result_t in_entry,
    output logic             out_valid,
    input  logic             out_ready,
    output mhd_pkg::result_t out_entry
);

    localparam int PTR_W = $clog2(mhd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mhd_pkg::QUEUE_DEPTH + 1);

    mhd_pkg::result_t entry_mem [mhd_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(mhd_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_entry = entry_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mhd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mhd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// ----- rtl/core/mhas_packet_deframer_top.sv -----
// A result word is registered in the output queue before it appears on m_.
// Throughput: one input word per cycle; the header parser decodes a whole byte per cycle.
// A two-word queue parts the parser from the output; input waits only while it holds two words.
// Reset: synchronous, active low; clears parser state and empties the queue at once.
module mhas_packet_deframer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,  // data_byte[7:0]
    input  logic                         s_tlast,  // stream_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mhd_pkg::TDATA_W-1:0]  m_tdata,  // packet_type[9:0], packet_label[42:10],
                                                   // payload_length[68:43],
                                                   // payload_byte[76:69], truncated[77]
    output logic [mhd_pkg::KIND_W-1:0]   m_tuser,  // kind[1:0]
    output logic                         m_tlast   // last
);

    mhd_pkg::result_t front_res;
    mhd_pkg::result_t head;
    logic             front_valid;
    logic             queue_ready;

    mhd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .res_valid (front_valid),
        .res_ready (queue_ready),
        .res       (front_res)
    );

    mhd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (queue_ready),
        .in_entry  (front_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_entry (head)
    );

    assign m_tdata = {2'b00, head.trunc, head.pbyte, head.length, head.label, head.ptype};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ----- rtl/core/mhd_checker.sv -----
module mhd_port_checks (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [mhd_pkg::TDATA_W-1:0]  m_tdata,
    input logic [mhd_pkg::KIND_W-1:0]   m_tuser,
    input logic                         m_tlast
);

    // kind code beyond the defined three
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == mhd_pkg::KIND_HEADER || m_tuser == mhd_pkg::KIND_PAYLOAD ||
                      m_tuser == mhd_pkg::KIND_HDR_END))
        else $error("illegal kind on result word");

    // stream end inside a header: last, truncated and zeroed fields
    a_hdr_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == mhd_pkg::KIND_HDR_END) |->
            (m_tlast && m_tdata[77] && m_tdata[76:0] == '0))
        else $error("stream end in header word malformed");

    // truncation ends the packet
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[77]) |-> m_tlast)
        else $error("truncated word without last");

    // payload byte field only carries data on payload words
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != mhd_pkg::KIND_PAYLOAD) |-> (m_tdata[76:69] == '0))
        else $error("payload byte set on non-payload word");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result word changed");

endmodule

bind mhas_packet_deframer_top mhd_port_checks u_mhd_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
